FILE: src/ts_pkg.sv
// ts_pkg: shared types and constants for the token scanner.
// Holds the scan mode and token kind encodings and the result entry type.
// No dependencies.
`timescale 1ns / 1ps

package ts_pkg;

  // Width of the internal position counter (saturates at all ones)
  localparam int POS_W   = 16;
  // Width of the reported start and length fields
  localparam int TOK_W   = 16;
  localparam int CH_W    = 8;
  localparam int KIND_W  = 4;
  // Result queue depth; one byte can push two results
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    K_IDENT  = 4'd0,
    K_INT    = 4'd1,
    K_EQUALS = 4'd2,
    K_ARROW  = 4'd3,
    K_LPAREN = 4'd4,
    K_RPAREN = 4'd5,
    K_LBRACE = 4'd6,
    K_RBRACE = 4'd7,
    K_COLON  = 4'd8,
    K_COMMA  = 4'd9,
    K_LT     = 4'd10,
    K_GT     = 4'd11,
    K_SEMI   = 4'd12,
    K_EOF    = 4'd13,
    K_ERROR  = 4'd14
  } kind_t;

  // One-hot scan mode
  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_IDENT = 5'b00010,
    M_INT   = 5'b00100,
    M_EQ    = 5'b01000,
    M_HALT  = 5'b10000
  } mode_t;

  // Characters with special meaning
  localparam logic [CH_W-1:0] CH_NUL = 8'd0;
  localparam logic [CH_W-1:0] CH_TAB = 8'd9;
  localparam logic [CH_W-1:0] CH_LF  = 8'd10;
  localparam logic [CH_W-1:0] CH_CR  = 8'd13;
  localparam logic [CH_W-1:0] CH_SP  = 8'h20;
  localparam logic [CH_W-1:0] CH_EQ  = 8'h3D;
  localparam logic [CH_W-1:0] CH_GT  = 8'h3E;

  typedef struct packed {
    kind_t            token_kind;
    logic [TOK_W-1:0] token_start;
    logic [TOK_W-1:0] token_length;
    logic             last_of_run;
  } res_t;

endpackage

FILE: src/ts_in_if.sv
// ts_in_if: byte request channel into the token scanner.
// Depends on ts_pkg for the byte width.
`timescale 1ns / 1ps

interface ts_in_if
  import ts_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

FILE: src/ts_out_if.sv
// ts_out_if: token result channel out of the token scanner.
// Depends on ts_pkg for field widths.
`timescale 1ns / 1ps

interface ts_out_if
  import ts_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [TOK_W-1:0]  token_start;
  logic [TOK_W-1:0]  token_length;
  logic              last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

FILE: src/token_scanner.sv
// token_scanner: streaming lexer, one source byte per request.
// Each accepted byte is registered in ch_r; its results are then written to the result queue that drives out_tok.
// Throughput: one byte per cycle while the queue has room for two results; a byte that flushes a
// token and also makes one pushes two results into a 4-entry result queue.
// Reset (rst_n low, synchronous): mode idle, position zero, queue empty.
// Depends on ts_pkg, ts_in_if, ts_out_if.
`timescale 1ns / 1ps

module token_scanner
  import ts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  ts_in_if.sink    in_ch,
  ts_out_if.source out_tok
);

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Input register
  logic            in_vld_r, in_vld_nxt;
  logic [CH_W-1:0] ch_r;
  logic            in_fire;

  // Scanner state
  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] ostart_r, ostart_nxt;

  // Result queue
  res_t            q_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            pop;
  logic            adv;

  // Classification and result building
  logic        is_letter, is_digit, is_sep, is_punct;
  kind_t       punct_k;
  logic        flush_v, own_v, skip_scan, is_err, is_eof;
  res_t        flush_res, own_res;
  res_t        res_a, res_b;
  logic [1:0]  wr_n;
  logic [POS_W-1:0] pos_inc;

  assign pop         = (cnt_r != '0) && out_tok.ready;
  assign adv         = in_vld_r && ((cnt_r - Q_CW'(pop)) <= Q_CW'(Q_DEPTH - 2));
  assign in_ch.ready = !in_vld_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_vld_nxt  = in_fire || (in_vld_r && !adv);

  // Byte classes
  always_comb begin
    is_letter = ch_r inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    is_digit  = ch_r inside {[8'h30:8'h39]};
    is_sep    = ch_r inside {CH_CR, CH_LF, CH_SP, CH_TAB};
    is_punct  = 1'b1;
    punct_k   = K_ERROR;
    case (ch_r)
      8'h28:   punct_k = K_LPAREN;
      8'h29:   punct_k = K_RPAREN;
      8'h7B:   punct_k = K_LBRACE;
      8'h7D:   punct_k = K_RBRACE;
      8'h3A:   punct_k = K_COLON;
      8'h2C:   punct_k = K_COMMA;
      8'h3C:   punct_k = K_LT;
      CH_GT:   punct_k = K_GT;
      8'h3B:   punct_k = K_SEMI;
      default: is_punct = 1'b0;
    endcase
  end

  assign pos_inc = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;

  // Token close / extend and the byte's own token
  always_comb begin
    flush_v    = 1'b0;
    skip_scan  = 1'b0;
    flush_res  = '{token_kind: K_IDENT, token_start: TOK_W'(ostart_r),
                   token_length: TOK_W'(pos_r - ostart_r), last_of_run: 1'b0};
    mode_nxt   = mode_r;
    pos_nxt    = pos_inc;
    ostart_nxt = ostart_r;
    own_v      = 1'b0;
    is_err     = 1'b0;
    is_eof     = 1'b0;
    own_res    = '{token_kind: K_ERROR, token_start: TOK_W'(pos_r),
                   token_length: TOK_W'(1), last_of_run: 1'b1};

    case (mode_r)
      M_IDENT: begin
        if (is_letter) skip_scan = 1'b1;
        else flush_v = 1'b1;
      end
      M_INT: begin
        flush_res.token_kind = K_INT;
        if (is_digit) skip_scan = 1'b1;
        else flush_v = 1'b1;
      end
      M_EQ: begin
        flush_v                = 1'b1;
        flush_res.token_length = TOK_W'(1);
        flush_res.token_kind   = K_EQUALS;
        if (ch_r == CH_GT) begin
          skip_scan              = 1'b1;
          flush_res.token_kind   = K_ARROW;
          flush_res.token_length = TOK_W'(2);
        end
      end
      default: ;
    endcase

    if (mode_r == M_HALT) begin
      flush_v   = 1'b0;
      skip_scan = 1'b1;
      pos_nxt   = pos_r;
    end else if (skip_scan) begin
      // Open token extended, or arrow completed
      if (mode_r == M_EQ) mode_nxt = M_IDLE;
    end else begin
      mode_nxt = M_IDLE;
      if (ch_r == CH_NUL) begin
        own_v                = 1'b1;
        is_eof               = 1'b1;
        own_res.token_kind   = K_EOF;
        own_res.token_length = '0;
        pos_nxt              = '0;
        ostart_nxt           = '0;
      end else if (is_letter) begin
        mode_nxt   = M_IDENT;
        ostart_nxt = pos_r;
      end else if (is_digit) begin
        mode_nxt   = M_INT;
        ostart_nxt = pos_r;
      end else if (ch_r == CH_EQ) begin
        mode_nxt   = M_EQ;
        ostart_nxt = pos_r;
      end else if (is_punct) begin
        own_v              = 1'b1;
        own_res.token_kind = punct_k;
      end else if (!is_sep) begin
        // Bad byte: report and stop, position does not advance
        own_v    = 1'b1;
        is_err   = 1'b1;
        mode_nxt = M_HALT;
        pos_nxt  = pos_r;
      end
    end

    // Order results: flushed token first
    flush_res.last_of_run = !own_v;
    res_a = flush_v ? flush_res : own_res;
    res_b = own_res;
    wr_n  = 2'(flush_v) + 2'(own_v);
  end

  assign cnt_nxt = cnt_r - Q_CW'(pop) + (adv ? Q_CW'(wr_n) : '0);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      ostart_r <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      cnt_r    <= cnt_nxt;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (adv) begin
        mode_r   <= mode_nxt;
        pos_r    <= pos_nxt;
        ostart_r <= ostart_nxt;
        wr_ptr_r <= wr_ptr_r + Q_AW'(wr_n);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) ch_r <= in_ch.ch;
    if (adv && wr_n != 2'd0) q_r[wr_ptr_r] <= res_a;
    if (adv && wr_n == 2'd2) q_r[wr_ptr_r + 1'b1] <= res_b;
  end

  // Result channel drive
  assign out_tok.valid        = (cnt_r != '0);
  assign out_tok.token_kind   = q_r[rd_ptr_r].token_kind;
  assign out_tok.token_start  = q_r[rd_ptr_r].token_start;
  assign out_tok.token_length = q_r[rd_ptr_r].token_length;
  assign out_tok.last_of_run  = q_r[rd_ptr_r].last_of_run;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH))
    else $error("result queue overflow");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_HALT |=> mode_r == M_HALT)
    else $error("left halt without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_HALT && adv) |-> wr_n == 2'd0)
    else $error("result produced while halted");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_err) |=> mode_r == M_HALT)
    else $error("error byte did not halt scanner");

  a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_eof) |=> (pos_r == '0 && mode_r == M_IDLE))
    else $error("eof did not restart position");

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for token_scanner, one source byte per request.
// Predicts each token from its own scanner state and checks every result in order.
// Depends on ts_pkg, ts_in_if, ts_out_if and the token_scanner RTL.
`timescale 1ns / 1ps

module tb;
  import ts_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int TAIL_CYCLES    = 10;
  localparam int RANDOM_BYTES   = 380;
  localparam int MAX_REPORTS    = 10;

  logic clk;
  logic rst_n;

  ts_in_if  in_ch ();
  ts_out_if out_tok ();

  token_scanner dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_tok (out_tok)
  );

  // Scanner state as predicted from the accepted bytes
  mode_t            scan_mode = M_IDLE;
  logic [POS_W-1:0] scan_pos  = '0;
  logic [POS_W-1:0] open_at   = '0;

  res_t expected_tokens[$];

  int    err_count      = 0;
  int    tokens_checked = 0;
  int    bytes_sent     = 0;
  int    burst_left     = 0;
  bit    fast_send      = 1'b0;
  int    holds_asked    = 0;
  int    holds_done     = 0;
  int    hold_cnt       = 0;
  int    rx_cycle       = 0;
  int    idle_cycles    = 0;
  string punct_chars    = "(){}:,<>;";
  logic [CH_W-1:0] separators [4] = '{CH_CR, CH_LF, CH_SP, CH_TAB};

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------
  function automatic bit is_letter(input logic [CH_W-1:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(input logic [CH_W-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Single-byte tokens; returns 0 when c is not one
  function automatic bit punct_kind(input logic [CH_W-1:0] c, output kind_t k);
    k = K_ERROR;
    case (c)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ":": k = K_COLON;
      ",": k = K_COMMA;
      "<": k = K_LT;
      ">": k = K_GT;
      ";": k = K_SEMI;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void push_token(input kind_t k, input logic [TOK_W-1:0] start,
                                     input logic [TOK_W-1:0] len);
    expected_tokens.push_back('{token_kind: k, token_start: start,
                                token_length: len, last_of_run: 1'b0});
  endfunction

  // Advance the predicted scanner by one byte and queue the tokens it completes
  function automatic void predict_tokens(input logic [CH_W-1:0] c);
    logic [POS_W-1:0] p;
    int               n_before;
    bit               absorbed;
    bit               hold_pos;
    kind_t            pk;
    p        = scan_pos;
    n_before = expected_tokens.size();
    absorbed = 1'b0;
    hold_pos = 1'b0;
    if (scan_mode == M_HALT) return;

    // close or extend the open token
    case (scan_mode)
      M_IDENT: begin
        if (is_letter(c)) absorbed = 1'b1;
        else begin
          push_token(K_IDENT, open_at, p - open_at);
          scan_mode = M_IDLE;
        end
      end
      M_INT: begin
        if (is_digit(c)) absorbed = 1'b1;
        else begin
          push_token(K_INT, open_at, p - open_at);
          scan_mode = M_IDLE;
        end
      end
      M_EQ: begin
        scan_mode = M_IDLE;
        if (c == CH_GT) begin
          push_token(K_ARROW, open_at, 16'd2);
          absorbed = 1'b1;
        end else begin
          push_token(K_EQUALS, open_at, 16'd1);
        end
      end
      default: scan_mode = M_IDLE;
    endcase

    // scan the byte itself
    if (!absorbed) begin
      if (c == CH_NUL) begin
        push_token(K_EOF, p, 16'd0);
        scan_pos = '0;
        open_at  = '0;
        hold_pos = 1'b1;
      end else if (is_letter(c)) begin
        scan_mode = M_IDENT;
        open_at   = p;
      end else if (is_digit(c)) begin
        scan_mode = M_INT;
        open_at   = p;
      end else if (c == CH_EQ) begin
        scan_mode = M_EQ;
        open_at   = p;
      end else if (punct_kind(c, pk)) begin
        push_token(pk, p, 16'd1);
      end else if (c == CH_CR || c == CH_LF || c == CH_SP || c == CH_TAB) begin
        // separator only
      end else begin
        push_token(K_ERROR, p, 16'd1);
        scan_mode = M_HALT;
        hold_pos  = 1'b1;
      end
    end

    // position saturates at all ones
    if (!hold_pos && scan_pos != {POS_W{1'b1}}) scan_pos = scan_pos + 1'b1;
    if (expected_tokens.size() > n_before)
      expected_tokens[expected_tokens.size()-1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Byte sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [CH_W-1:0] c);
    int gap;
    if (!fast_send && burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.ch    <= c;
    do @(posedge clk); while (!in_ch.ready);
    predict_tokens(c);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // Stop offering bytes until every predicted token has come out
  task automatic wait_for_tokens();
    in_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CH_W-1:0] random_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  function automatic logic [CH_W-1:0] random_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // Any byte that does not halt the scanner
  function automatic logic [CH_W-1:0] random_legal_byte();
    case ($urandom_range(0, 6))
      0: return random_letter();
      1: return random_digit();
      2: return CH_EQ;
      3: return CH_GT;
      4: return separators[$urandom_range(0, 3)];
      5: return CH_NUL;
      default: return punct_chars[$urandom_range(0, 8)];
    endcase
  endfunction

  // One well-formed token with random content, or a little noise
  task automatic send_random_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      repeat ($urandom_range(1, 6)) send_byte(random_letter());
    end else if (r < 45) begin
      repeat ($urandom_range(1, 5)) send_byte(random_digit());
    end else if (r < 60) begin
      send_byte(punct_chars[$urandom_range(0, 8)]);
    end else if (r < 68) begin
      send_byte(CH_EQ);
    end else if (r < 76) begin
      send_byte(CH_EQ);
      send_byte(CH_GT);
    end else if (r < 90) begin
      send_byte(separators[$urandom_range(0, 3)]);
    end else if (r < 95) begin
      send_byte(CH_NUL);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(random_legal_byte());
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Every single-byte token, every separator
  task automatic test_punctuation();
    send_text("(){}:,<>;");
    send_byte(CH_SP);
    send_byte(CH_TAB);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // Letter and digit extremes, runs back to back, '=' lookahead, trailing '=' at eof
  task automatic test_runs_and_lookahead();
    send_text("Az09=>Za==9=");
    send_byte(CH_NUL);
  endtask

  // Long receiver hold-off while bytes keep coming, then a full drain
  task automatic test_backpressure();
    fast_send = 1'b1;
    holds_asked++;
    repeat (15) send_text("a(");
    while (holds_done != holds_asked) @(posedge clk);
    fast_send = 1'b0;
    wait_for_tokens();
    send_text("x1;");
  endtask

  task automatic test_random_text();
    int start_count;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) send_random_token();
  endtask

  // A bad byte after an open identifier; everything after it is ignored
  task automatic test_error_halt();
    send_text("ab");
    send_byte(8'($urandom_range(128, 255)));
    send_text("q7(=>");
    send_byte(CH_NUL);
    repeat (8) send_byte(random_legal_byte());
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall pattern of its own plus requested long holds
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tok.ready <= 1'b0;
    end else if (holds_done < holds_asked) begin
      out_tok.ready <= 1'b0;
      if (hold_cnt == HOLD_CYCLES - 1) begin
        hold_cnt = 0;
        holds_done++;
      end else begin
        hold_cnt++;
      end
    end else begin
      rx_cycle++;
      case ((rx_cycle / 150) % 4)
        0: out_tok.ready <= 1'b1;
        1: out_tok.ready <= ($urandom_range(0, 9) >= 3);
        2: out_tok.ready <= (rx_cycle % 3 != 0);
        default: out_tok.ready <= ($urandom_range(0, 9) >= 6);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_tokens
    res_t want;
    if (rst_n && out_tok.valid && out_tok.ready) begin
      if (expected_tokens.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("Unexpected token: kind %0d start %0d len %0d last %0b",
                   out_tok.token_kind, out_tok.token_start, out_tok.token_length,
                   out_tok.last_of_run);
      end else begin
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (out_tok.token_kind != want.token_kind ||
            out_tok.token_start != want.token_start ||
            out_tok.token_length != want.token_length ||
            out_tok.last_of_run != want.last_of_run) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("Token %0d mismatch: expected kind %0d start %0d len %0d last %0b",
                     tokens_checked, want.token_kind, want.token_start,
                     want.token_length, want.last_of_run);
            $display("  got kind %0d start %0d len %0d last %0b",
                     out_tok.token_kind, out_tok.token_start,
                     out_tok.token_length, out_tok.last_of_run);
          end
        end
      end
    end
  end

  // Watchdog: too long with no request accepted on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_tok.valid && out_tok.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no request accepted for %0d cycles, %0d tokens pending",
                 WATCHDOG_LIMIT, expected_tokens.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.ch    <= CH_NUL;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_punctuation();
    test_runs_and_lookahead();
    test_backpressure();
    test_random_text();
    test_error_halt();

    wait_for_tokens();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Scanned %0d bytes: punctuation, runs, '=' lookahead, random token streams,",
             bytes_sent);
    $display("long output stalls and halt on a bad byte; %0d tokens, %0d errors",
             tokens_checked, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: token_scanner.f
src/ts_pkg.sv
src/ts_in_if.sv
src/ts_out_if.sv
src/token_scanner.sv
bench/tb.sv
